/* rtl/toc_pkg.sv */
// ----------------------------------------------------------------------------
// toc_pkg
// shared constants, command and state types for the triangle occurrence counter
// ----------------------------------------------------------------------------
package toc_pkg;

  localparam int NODES      = 32;
  localparam int COUNT_BITS = 16;
  localparam int TRIPLES    = NODES * (NODES - 1) * (NODES - 2) / 6;

  localparam int NODE_W  = $clog2(NODES);
  localparam int IDX_W   = $clog2(TRIPLES);
  localparam int VALUE_W = 16;

  // fixed field widths of the channels
  localparam int KIND_FIELD_W  = 2;
  localparam int NODE_FIELD_W  = 6;
  localparam int INDEX_FIELD_W = 13;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // request kinds
  localparam logic [KIND_FIELD_W-1:0] KIND_EDGE = 2'd0;
  localparam logic [KIND_FIELD_W-1:0] KIND_END  = 2'd1;
  localparam logic [KIND_FIELD_W-1:0] KIND_READ = 2'd2;

  // response kinds
  localparam logic RESP_REPORT = 1'b0;
  localparam logic RESP_READ   = 1'b1;

  localparam logic [31:0] VALUE_MAX = 32'h0000_FFFF;

  typedef enum logic [1:0] {
    OP_EDGE,
    OP_END,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [NODE_W-1:0] lo;
    logic [NODE_W-1:0] hi;
    logic [IDX_W-1:0]  idx;
    logic              idx_ok;
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EDGE_RD,
    S_EDGE_WR,
    S_LOAD,
    S_WALK,
    S_DRAIN,
    S_READ,
    S_EMIT
  } state_t;

  // clamp a counter to the width of the value field
  function automatic logic [VALUE_W-1:0] sat_value(input logic [COUNT_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    if (w > VALUE_MAX) begin
      return '1;
    end
    return w[VALUE_W-1:0];
  endfunction

endpackage

/* rtl/toc_ifs.sv */
// ----------------------------------------------------------------------------
// toc_ifs
// request and response channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface toc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  node_a;
  logic [5:0]  node_b;
  logic [12:0] triple_index;

  modport source (output valid, output kind, output node_a, output node_b,
                  output triple_index, input ready);
  modport sink   (input valid, input kind, input node_a, input node_b,
                  input triple_index, output ready);
endinterface

interface toc_resp_if;
  logic        valid;
  logic        ready;
  logic        resp_kind;
  logic [15:0] value;

  modport source (output valid, output resp_kind, output value, input ready);
  modport sink   (input valid, input resp_kind, input value, output ready);
endinterface

/* rtl/toc_ram.sv */
// ----------------------------------------------------------------------------
// toc_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module toc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/toc_queue.sv */
// ----------------------------------------------------------------------------
// toc_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module toc_queue
  import toc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = (fill == (QPTR_W + 1)'(QDEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/toc_front.sv */
// ----------------------------------------------------------------------------
// toc_front
// accepts request words and turns them into queued commands
// ----------------------------------------------------------------------------
module toc_front
  import toc_pkg::*;
(
  toc_req_if.sink req,
  input  logic    q_full,
  input  logic    clearing,
  output logic    push,
  output cmd_t    push_cmd
);

  logic                    a_ok;
  logic                    b_ok;
  logic                    edge_ok;
  logic [NODE_FIELD_W-1:0] n_lo;
  logic [NODE_FIELD_W-1:0] n_hi;
  logic                    keep;

  assign req.ready = !q_full && !clearing;

  always_comb begin
    a_ok    = (req.node_a != '0) && (32'(req.node_a) <= 32'(NODES));
    b_ok    = (req.node_b != '0) && (32'(req.node_b) <= 32'(NODES));
    // self loops never feed a triple, so drop them here
    edge_ok = a_ok && b_ok && (req.node_a != req.node_b);
    if (req.node_a < req.node_b) begin
      n_lo = req.node_a;
      n_hi = req.node_b;
    end else begin
      n_lo = req.node_b;
      n_hi = req.node_a;
    end

    push_cmd.lo     = NODE_W'(n_lo - NODE_FIELD_W'(1));
    push_cmd.hi     = NODE_W'(n_hi - NODE_FIELD_W'(1));
    push_cmd.idx    = IDX_W'(req.triple_index);
    push_cmd.idx_ok = (32'(req.triple_index) < 32'(TRIPLES));

    unique case (req.kind)
      KIND_EDGE: begin
        push_cmd.op = OP_EDGE;
        keep        = edge_ok;
      end
      KIND_END: begin
        push_cmd.op = OP_END;
        keep        = 1'b1;
      end
      KIND_READ: begin
        push_cmd.op = OP_READ;
        keep        = 1'b1;
      end
      default: begin
        push_cmd.op = OP_EDGE;
        keep        = 1'b0;
      end
    endcase

    push = req.valid && req.ready && keep;
  end

endmodule

/* rtl/toc_back.sv */
// ----------------------------------------------------------------------------
// toc_back
// executes commands: adjacency updates, triple walk, counter reads
// ----------------------------------------------------------------------------
module toc_back
  import toc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t head,
  input  logic q_empty,
  output logic pop,
  output logic clearing,
  toc_resp_if.source resp
);

  state_t state;
  state_t state_next;

  cmd_t               cur;
  logic [NODE_W-1:0]  i;
  logic [NODE_W-1:0]  j;
  logic [NODE_W-1:0]  k;
  logic [IDX_W-1:0]   pos;
  logic [IDX_W-1:0]   clr_addr;
  logic [VALUE_W-1:0] found;
  logic [NODES-1:0]   row_vld;
  logic               vld_a;
  logic               vld_b;

  // adjacency rows, upper triangle only, two copies for two reads
  logic              adj_we;
  logic [NODE_W-1:0] adj_wa;
  logic [NODES-1:0]  adj_wd;
  logic [NODE_W-1:0] adj_ra;
  logic [NODE_W-1:0] adj_rb;
  logic [NODES-1:0]  adj_qa;
  logic [NODES-1:0]  adj_qb;
  logic [NODES-1:0]  row_a;
  logic [NODES-1:0]  row_b;

  // triple counters
  logic                  cnt_we;
  logic [IDX_W-1:0]      cnt_wa;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic [IDX_W-1:0]      cnt_ra;
  logic [COUNT_BITS-1:0] cnt_q;

  // counter update stage
  logic             p_vld;
  logic             p_tri;
  logic [IDX_W-1:0] p_pos;

  logic               ovld;
  logic               okind;
  logic [VALUE_W-1:0] oval;

  logic tri_hit;
  logic last_k;
  logic last_j;
  logic last_i;
  logic out_free;
  logic emit;

  toc_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj_a (
    .clk(clk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd),
    .raddr(adj_ra), .rdata(adj_qa)
  );

  toc_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj_b (
    .clk(clk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd),
    .raddr(adj_rb), .rdata(adj_qb)
  );

  toc_ram #(.WIDTH(COUNT_BITS), .DEPTH(TRIPLES)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
    .raddr(cnt_ra), .rdata(cnt_q)
  );

  assign resp.valid     = ovld;
  assign resp.resp_kind = okind;
  assign resp.value     = oval;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == IDX_W'(TRIPLES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          unique case (head.op)
            OP_EDGE: state_next = S_EDGE_RD;
            OP_END:  state_next = S_LOAD;
            OP_READ: state_next = S_READ;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_EDGE_RD: state_next = S_EDGE_WR;
      S_EDGE_WR: state_next = S_IDLE;
      S_LOAD:    state_next = S_WALK;
      S_WALK: begin
        if (last_k) begin
          state_next = (last_i && last_j) ? S_DRAIN : S_LOAD;
        end
      end
      S_DRAIN:   state_next = S_EMIT;
      S_READ:    state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    clearing = (state == S_CLEAR);
    pop      = (state == S_IDLE) && !q_empty;
    out_free = !ovld || resp.ready;
    emit     = (state == S_EMIT) && out_free;

    adj_ra = (state == S_EDGE_RD) ? cur.lo : i;
    adj_rb = j;
    row_a  = vld_a ? adj_qa : '0;
    row_b  = vld_b ? adj_qb : '0;
    adj_we = (state == S_EDGE_WR);
    adj_wa = cur.lo;
    adj_wd = row_a | (NODES'(1) << cur.hi);

    tri_hit = row_a[j] && row_a[k] && row_b[k];
    last_k  = (k == NODE_W'(NODES - 1));
    last_j  = (j == NODE_W'(NODES - 2));
    last_i  = (i == NODE_W'(NODES - 3));

    cnt_ra = (state == S_WALK) ? pos : cur.idx;
    if (state == S_CLEAR) begin
      cnt_we = 1'b1;
      cnt_wa = clr_addr;
      cnt_wd = '0;
    end else begin
      cnt_we = p_vld && p_tri;
      cnt_wa = p_pos;
      cnt_wd = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      row_vld  <= '0;
      p_vld    <= 1'b0;
      ovld     <= 1'b0;
    end else begin
      state <= state_next;
      p_vld <= (state == S_WALK);
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_EDGE_WR) begin
        row_vld[cur.lo] <= 1'b1;
      end else if (state == S_DRAIN) begin
        row_vld <= '0;
      end
      if (emit) begin
        ovld <= 1'b1;
      end else if (resp.ready) begin
        ovld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    vld_a <= row_vld[adj_ra];
    vld_b <= row_vld[adj_rb];
    p_tri <= tri_hit;
    p_pos <= pos;
    if (pop) begin
      cur   <= head;
      i     <= '0;
      j     <= NODE_W'(1);
      pos   <= '0;
      found <= '0;
    end
    if (state == S_LOAD) begin
      k <= j + 1'b1;
    end
    if (state == S_WALK) begin
      pos <= pos + 1'b1;
      k   <= k + 1'b1;
      if (tri_hit && (found != '1)) begin
        found <= found + 1'b1;
      end
      if (last_k) begin
        if (last_j) begin
          i <= i + 1'b1;
          j <= i + NODE_W'(2);
        end else begin
          j <= j + 1'b1;
        end
      end
    end
    if (emit) begin
      if (cur.op == OP_END) begin
        okind <= RESP_REPORT;
        oval  <= found;
      end else begin
        okind <= RESP_READ;
        oval  <= cur.idx_ok ? sat_value(cnt_q) : '0;
      end
    end
  end

endmodule

/* rtl/triangle_occurrence_counter.sv */
// ----------------------------------------------------------------------------
// triangle_occurrence_counter
// counts per node triple how often it forms a triangle over many graphs
// ----------------------------------------------------------------------------
// req channel: one word per item, kind selects add edge, end of graph or
//   read counter. edges naming node 0, a node above NODES, or a self loop,
//   and kind 3, are taken and dropped without a response.
// resp channel: one word per end of graph (resp_kind 0, triangle count) and
//   per read (resp_kind 1, counter value, 0 for an index past the last triple).
// the front classifies words into a four deep command queue; the back runs
//   one command at a time, so req keeps flowing while the back is busy.
// work per command once it leaves the queue: edge is an adjacency
//   read-modify-write, read is a counter read plus response, end of graph
//   walks every triple, one triple a cycle except for the row reload per
//   pair, set by the single counter ram port pair.
// reset: counters are swept to zero, one per cycle, over all triples; req.ready
//   stays low during the sweep. adjacency rows clear at once via valid bits.
// a stalled receiver holds the response register; the back waits in its
//   emit state and the queue fills up behind it.
// ----------------------------------------------------------------------------
module triangle_occurrence_counter
  import toc_pkg::*;
(
  input logic         clk,
  input logic         rst,
  toc_req_if.sink     req,
  toc_resp_if.source  resp
);

  // queue handshake between the two halves
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  cmd_t head;
  logic q_empty;
  logic clearing;

  // front: decode request words into commands
  toc_front u_front (
    .req      (req),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decoupling queue
  toc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  // back: adjacency store, triple walk, counter store, response register
  toc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .clearing (clearing),
    .resp     (resp)
  );

endmodule
